// ===== rtl/core/range_refcount_table_macros.svh =====
// Assertion macros for the reference count table
`ifndef RANGE_REFCOUNT_TABLE_MACROS_SVH
`define RANGE_REFCOUNT_TABLE_MACROS_SVH

// Same-cycle implication, idle during reset
`define RRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("range_refcount_table: assertion failed");

// Next-cycle implication, idle during reset
`define RRT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("range_refcount_table: assertion failed");

`endif

// ===== rtl/core/rrt_pkg.sv =====
package rrt_pkg;

	localparam int TABLE_RECORDS = 32;
	localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INC    = 2'd1;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef struct packed {
		logic [63:0] start;
		logic [31:0] len;
		logic [31:0] cnt;
	} rec_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic        valid;
		logic        clear;
		logic        flush;
		logic [63:0] p;
		logic [63:0] e;
		logic [31:0] cnt;
	} emit_req_t;

	function automatic logic [31:0] adjust_cnt(input logic [31:0] c, input logic inc);
		logic [31:0] r;
		if (inc) begin
			r = (c == LEN_MAX) ? c : c + 32'd1;
		end else begin
			r = (c == 32'd0) ? c : c - 32'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/rrt_cell.sv =====
module rrt_cell (
	input  logic              clk,
	input  rrt_pkg::cell_ctl_t ctl,
	input  rrt_pkg::rec_t     shift_in,
	input  rrt_pkg::rec_t     load_in,
	output rrt_pkg::rec_t     q
);

	rrt_pkg::rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= load_in;
		end else if (ctl.shift) begin
			rec_q <= shift_in;
		end
	end

	assign q = rec_q;

endmodule

// ===== rtl/core/rrt_merge.sv =====
module rrt_merge #(
	parameter int RECS = rrt_pkg::TABLE_RECORDS,
	localparam int WNW = $clog2(RECS + 2),
	localparam int FNW = $clog2(RECS + 3)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rrt_pkg::emit_req_t  req,
	output logic [RECS-1:0]     wk_load,
	output logic [RECS:0]       fr_load,
	output rrt_pkg::rec_t       wk_data,
	output rrt_pkg::rec_t       fr_data,
	output logic [WNW-1:0]      wk_n,
	output logic [FNW-1:0]      fr_n
);

	rrt_pkg::rec_t  wk_pend_q;
	rrt_pkg::rec_t  fr_pend_q;
	logic [WNW-1:0] wk_n_q;
	logic [FNW-1:0] fr_n_q;

	logic [63:0] diff;
	logic [31:0] n;
	logic        live;
	logic        flushing;
	logic        is_free;
	logic        is_one;
	logic [32:0] fr_sum;
	logic [32:0] wk_sum;
	logic        fr_join;
	logic        wk_join;
	logic        fr_push;
	logic        wk_push;
	logic        fr_store;
	logic        wk_store;

	always_comb begin
		diff     = req.e - req.p;
		n        = diff[31:0];
		live     = req.valid && !req.clear && !req.flush && (req.e > req.p);
		flushing = req.valid && req.flush;
		is_free  = (req.cnt == 32'd0);
		is_one   = (req.cnt == 32'd1);
		fr_sum   = {1'b0, fr_pend_q.len} + {1'b0, n};
		wk_sum   = {1'b0, wk_pend_q.len} + {1'b0, n};
		fr_join  = (fr_n_q != '0) && !fr_sum[32] &&
			((fr_pend_q.start + 64'(fr_pend_q.len)) == req.p);
		wk_join  = (wk_n_q != '0) && !wk_sum[32] && (wk_pend_q.cnt == req.cnt) &&
			((wk_pend_q.start + 64'(wk_pend_q.len)) == req.p);
		fr_push  = live && is_free && !fr_join && (fr_n_q < FNW'(RECS + 2));
		wk_push  = live && !is_free && !is_one && !wk_join && (wk_n_q <= WNW'(RECS));
		fr_store = (fr_push || flushing) && (fr_n_q != '0) && (fr_n_q <= FNW'(RECS + 1));
		wk_store = (wk_push || flushing) && (wk_n_q != '0) && (wk_n_q <= WNW'(RECS));
	end

	for (genvar j = 0; j < RECS; j++) begin : g_wk
		assign wk_load[j] = wk_store && (wk_n_q == WNW'(j + 1));
	end

	for (genvar j = 0; j <= RECS; j++) begin : g_fr
		assign fr_load[j] = fr_store && (fr_n_q == FNW'(j + 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wk_n_q <= '0;
			fr_n_q <= '0;
		end else if (req.valid && req.clear) begin
			wk_n_q <= '0;
			fr_n_q <= '0;
		end else begin
			if (wk_push) begin
				wk_n_q <= wk_n_q + WNW'(1);
			end
			if (fr_push) begin
				fr_n_q <= fr_n_q + FNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fr_push) begin
			fr_pend_q <= '{start: req.p, len: n, cnt: 32'd0};
		end else if (live && is_free && fr_join) begin
			fr_pend_q.len <= fr_sum[31:0];
		end
		if (wk_push) begin
			wk_pend_q <= '{start: req.p, len: n, cnt: req.cnt};
		end else if (live && !is_free && !is_one && wk_join) begin
			wk_pend_q.len <= wk_sum[31:0];
		end
	end

	assign wk_data = wk_pend_q;
	assign fr_data = fr_pend_q;
	assign wk_n    = wk_n_q;
	assign fr_n    = fr_n_q;

endmodule

// ===== rtl/core/range_refcount_table.sv =====
// Range reference count table for one allocation group.
// Request channel: in_valid / in_stall with mode, start_block, range_length.
// Result channel: out_valid / out_stall with status, refcount, freed_valid,
// freed_start, freed_length and last; a request yields one result, or one
// per released range on a decrement, the final one marked by last.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 first block,
// 1 block count) and cfg_data; write only while the block is idle.
// One request is in flight at a time; in_stall is high from acceptance
// until the final result sits in the output register.
// Lookup: the record chain rotates once past its head cell, then the result loads.
// Update: the record chain rotates past its head cell while the work and free
// chains are built; then, unless the work chain overflows, it is committed and
// each released range is sent as its own result.
// Out-of-group lookups and invalid requests go from the check to the result.
// Reset empties the table and clears the group registers; no sweep.
// While out_stall is high a valid result is held and the block waits to load another.
`include "range_refcount_table_macros.svh"

module range_refcount_table #(
	parameter int TABLE_RECORDS = rrt_pkg::TABLE_RECORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] start_block,
	input  logic [31:0] range_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] refcount,
	output logic        freed_valid,
	output logic [63:0] freed_start,
	output logic [31:0] freed_length,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int RECS = TABLE_RECORDS;
	localparam int IW   = $clog2(RECS + 1);
	localparam int WNW  = $clog2(RECS + 2);
	localparam int FNW  = $clog2(RECS + 3);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_CHECK  = 10'b00_0000_0010,
		S_LOOK   = 10'b00_0000_0100,
		S_PRE    = 10'b00_0000_1000,
		S_MID    = 10'b00_0001_0000,
		S_TAIL   = 10'b00_0010_0000,
		S_DRAIN  = 10'b00_0100_0000,
		S_ROT    = 10'b00_1000_0000,
		S_RESULT = 10'b01_0000_0000,
		S_FREE   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [63:0] first_q;
	logic [63:0] count_q;
	logic [1:0]  mode_q;
	logic [63:0] s_q;
	logic [31:0] len_q;
	logic [63:0] p_q, p_d;
	logic [63:0] b_q, b_d;
	logic [IW-1:0] i_q, i_d;
	logic [IW-1:0] used_q, used_d;
	logic [IW-1:0] outk_q, outk_d;
	logic [1:0]  res_status_q, res_status_d;
	logic [31:0] res_cnt_q, res_cnt_d;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] refcount_q;
	logic        freed_valid_q;
	logic [63:0] freed_start_q;
	logic [31:0] freed_length_q;
	logic        last_q;

	rrt_pkg::emit_req_t req_d, req_s1;

	rrt_pkg::rec_t tbl_q [RECS];
	rrt_pkg::rec_t wk_q  [RECS];
	rrt_pkg::rec_t fr_q  [RECS+1];

	rrt_pkg::cell_ctl_t tbl_ctl;
	rrt_pkg::cell_ctl_t wk_ctl [RECS];
	rrt_pkg::cell_ctl_t fr_ctl [RECS+1];

	logic [RECS-1:0] wk_load;
	logic [RECS:0]   fr_load;
	rrt_pkg::rec_t   wk_data;
	rrt_pkg::rec_t   fr_data;
	logic [WNW-1:0]  wk_n;
	logic [FNW-1:0]  fr_n;

	logic          rotate;
	logic          commit;
	logic          fr_shift;
	logic          res_ld;
	logic          free_ld;
	logic          out_ld;
	logic          accept;
	logic          last_free;
	rrt_pkg::rec_t h;
	logic [63:0]   h_end;
	logic          hv;
	logic          in_group;
	logic [64:0]   b_sum;
	logic          bad;
	logic          inc;
	logic [63:0]   seg_end;
	logic [63:0]   gap_end;

	function automatic rrt_pkg::emit_req_t mk_emit(input logic [63:0] p,
			input logic [63:0] e, input logic [31:0] c);
		rrt_pkg::emit_req_t r;
		r       = '0;
		r.valid = 1'b1;
		r.p     = p;
		r.e     = e;
		r.cnt   = c;
		return r;
	endfunction

	// record chain: rotate towards the head, load from the work chain on commit
	assign tbl_ctl = '{shift: rotate, load: commit};

	for (genvar j = 0; j < RECS; j++) begin : g_tbl
		rrt_cell u_cell (
			.clk      (clk),
			.ctl      (tbl_ctl),
			.shift_in (tbl_q[(j + 1) % RECS]),
			.load_in  (wk_q[j]),
			.q        (tbl_q[j])
		);
	end

	for (genvar j = 0; j < RECS; j++) begin : g_wk
		assign wk_ctl[j] = '{shift: 1'b0, load: wk_load[j]};
		rrt_cell u_cell (
			.clk      (clk),
			.ctl      (wk_ctl[j]),
			.shift_in (wk_q[j]),
			.load_in  (wk_data),
			.q        (wk_q[j])
		);
	end

	for (genvar j = 0; j <= RECS; j++) begin : g_fr
		assign fr_ctl[j] = '{shift: fr_shift, load: fr_load[j]};
		rrt_cell u_cell (
			.clk      (clk),
			.ctl      (fr_ctl[j]),
			.shift_in (fr_q[(j < RECS) ? j + 1 : j]),
			.load_in  (fr_data),
			.q        (fr_q[j])
		);
	end

	rrt_merge #(
		.RECS (RECS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_s1),
		.wk_load (wk_load),
		.fr_load (fr_load),
		.wk_data (wk_data),
		.fr_data (fr_data),
		.wk_n    (wk_n),
		.fr_n    (fr_n)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_ld    = !out_valid_q || !out_stall;

	always_comb begin
		h        = tbl_q[0];
		h_end    = h.start + 64'(h.len);
		hv       = (i_q < used_q);
		in_group = (s_q >= first_q) && ((s_q - first_q) < count_q);
		b_sum    = {1'b0, s_q} + 65'(len_q);
		bad      = (mode_q == rrt_pkg::MODE_NONE) || !in_group || (len_q == 32'd0) ||
			b_sum[64];
		inc      = (mode_q == rrt_pkg::MODE_INC);
		seg_end  = (h_end < b_q) ? h_end : b_q;
		gap_end  = (hv && (h.start < b_q)) ? h.start : b_q;
		last_free = ((FNW'(outk_q) + FNW'(1)) == fr_n) || (outk_q == IW'(RECS));
	end

	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		p_d          = p_q;
		b_d          = b_q;
		used_d       = used_q;
		outk_d       = outk_q;
		res_status_d = res_status_q;
		res_cnt_d    = res_cnt_q;
		req_d        = '0;
		rotate       = 1'b0;
		commit       = 1'b0;
		fr_shift     = 1'b0;
		res_ld       = 1'b0;
		free_ld      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				i_d          = '0;
				res_cnt_d    = 32'd1;
				res_status_d = rrt_pkg::STAT_OK;
				if (mode_q == rrt_pkg::MODE_LOOKUP) begin
					state_d = in_group ? S_LOOK : S_RESULT;
				end else if (bad) begin
					res_status_d = rrt_pkg::STAT_INVALID;
					res_cnt_d    = 32'd0;
					state_d      = S_RESULT;
				end else begin
					b_d         = b_sum[63:0];
					req_d.valid = 1'b1;
					req_d.clear = 1'b1;
					state_d     = S_PRE;
				end
			end
			S_LOOK: begin
				rotate = 1'b1;
				i_d    = i_q + IW'(1);
				if (hv && (s_q >= h.start) && (s_q < h_end)) begin
					res_cnt_d = h.cnt;
				end
				if (i_q == IW'(RECS - 1)) begin
					state_d = S_RESULT;
				end
			end
			S_PRE: begin
				if (hv && (h_end <= s_q)) begin
					req_d  = mk_emit(h.start, h_end, h.cnt);
					rotate = 1'b1;
					i_d    = i_q + IW'(1);
				end else begin
					if (hv && (h.start < s_q) && (h_end > s_q)) begin
						req_d = mk_emit(h.start, s_q, h.cnt);
					end
					p_d     = s_q;
					state_d = S_MID;
				end
			end
			S_MID: begin
				if (p_q < b_q) begin
					if (hv && (h.start <= p_q) && (p_q < h_end)) begin
						req_d = mk_emit(p_q, seg_end, rrt_pkg::adjust_cnt(h.cnt, inc));
						p_d   = seg_end;
						if (h_end <= b_q) begin
							rotate = 1'b1;
							i_d    = i_q + IW'(1);
						end
					end else begin
						req_d = mk_emit(p_q, gap_end, inc ? 32'd2 : 32'd0);
						p_d   = gap_end;
					end
				end else begin
					if (hv && (h.start < b_q) && (h_end > b_q)) begin
						req_d  = mk_emit(b_q, h_end, h.cnt);
						rotate = 1'b1;
						i_d    = i_q + IW'(1);
					end
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				if (hv) begin
					req_d  = mk_emit(h.start, h_end, h.cnt);
					rotate = 1'b1;
					i_d    = i_q + IW'(1);
				end else begin
					req_d.valid = 1'b1;
					req_d.flush = 1'b1;
					state_d     = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (i_q != IW'(RECS)) begin
					rotate = 1'b1;
					i_d    = i_q + IW'(1);
				end
				state_d = S_ROT;
			end
			S_ROT: begin
				res_cnt_d    = 32'd0;
				res_status_d = rrt_pkg::STAT_OK;
				if (i_q != IW'(RECS)) begin
					rotate = 1'b1;
					i_d    = i_q + IW'(1);
				end else if (wk_n > WNW'(RECS)) begin
					res_status_d = rrt_pkg::STAT_FULL;
					state_d      = S_RESULT;
				end else begin
					commit = 1'b1;
					used_d = IW'(wk_n);
					outk_d = '0;
					if (inc || (fr_n == '0)) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_FREE;
					end
				end
			end
			S_RESULT: begin
				if (out_ld) begin
					res_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				if (out_ld) begin
					free_ld  = 1'b1;
					fr_shift = 1'b1;
					if (last_free) begin
						state_d = S_IDLE;
					end else begin
						outk_d = outk_q + IW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			req_s1      <= '0;
			first_q     <= '0;
			count_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			used_q  <= used_d;
			req_s1  <= req_d;
			if (res_ld || free_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rrt_pkg::CFG_FIRST: first_q <= cfg_data;
					rrt_pkg::CFG_COUNT: count_q <= cfg_data;
					default: first_q <= first_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			s_q    <= start_block;
			len_q  <= range_length;
		end
		p_q          <= p_d;
		b_q          <= b_d;
		outk_q       <= outk_d;
		res_status_q <= res_status_d;
		res_cnt_q    <= res_cnt_d;
		if (res_ld) begin
			status_q       <= res_status_q;
			refcount_q     <= res_cnt_q;
			freed_valid_q  <= 1'b0;
			freed_start_q  <= '0;
			freed_length_q <= '0;
			last_q         <= 1'b1;
		end else if (free_ld) begin
			status_q       <= rrt_pkg::STAT_OK;
			refcount_q     <= '0;
			freed_valid_q  <= 1'b1;
			freed_start_q  <= fr_q[0].start;
			freed_length_q <= fr_q[0].len;
			last_q         <= last_free;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign refcount     = refcount_q;
	assign freed_valid  = freed_valid_q;
	assign freed_start  = freed_start_q;
	assign freed_length = freed_length_q;
	assign last         = last_q;

	`RRT_ASSERT_IMP(a_used_cap, 1'b1, used_q <= IW'(RECS))
	`RRT_ASSERT_IMP(a_rot_done, (state_q == S_ROT) && (state_d != S_ROT), i_q == IW'(RECS))
	`RRT_ASSERT_IMP(a_free_bound, state_q == S_FREE, FNW'(outk_q) < fr_n)
	`RRT_ASSERT_NEXT(a_commit_used, commit, used_q <= IW'(RECS))

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_DEC = 2'd2;
	localparam int WORK_SIZE = 2 * rrt_pkg::TABLE_RECORDS + 4;
	localparam int FREE_SIZE = rrt_pkg::TABLE_RECORDS + 2;
	localparam logic [63:0] BLK_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]  st;
		logic [31:0] rc;
		logic        fv;
		logic [63:0] fs;
		logic [31:0] fl;
		logic        lst;
	} result_t;

	typedef struct {
		logic [63:0] s;
		logic [31:0] l;
		logic [31:0] c;
	} span_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [63:0] start_block;
	logic [31:0] range_length;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] refcount;
	logic        freed_valid;
	logic [63:0] freed_start;
	logic [31:0] freed_length;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [63:0] cfg_data;

	int  error_count = 0;
	bit  calm = 0;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	class refcount_scoreboard;
		logic [63:0] grp_first = '0;
		logic [63:0] grp_count = '0;
		logic [63:0] rec_start [rrt_pkg::TABLE_RECORDS];
		logic [31:0] rec_len [rrt_pkg::TABLE_RECORDS];
		logic [31:0] rec_cnt [rrt_pkg::TABLE_RECORDS];
		int          rec_used = 0;
		span_t       wk [$];
		span_t       fr [$];
		result_t     pending [$];

		function void set_reg(logic idx, logic [63:0] v);
			if (idx == rrt_pkg::CFG_FIRST) grp_first = v;
			else grp_count = v;
		endfunction

		function logic [31:0] bump(logic [31:0] c, bit inc);
			if (inc) return (c == rrt_pkg::LEN_MAX) ? c : c + 32'd1;
			return (c == 32'd0) ? c : c - 32'd1;
		endfunction

		function void emit(logic [63:0] p, logic [63:0] e, logic [31:0] c);
			logic [31:0] n;
			int k;
			if (e <= p) return;
			n = 32'(e - p);
			if (c == 0) begin
				k = fr.size();
				if (k > 0 && fr[k-1].s + fr[k-1].l == p &&
						{1'b0, fr[k-1].l} + n <= rrt_pkg::LEN_MAX)
					fr[k-1].l += n;
				else if (k < FREE_SIZE)
					fr.push_back('{p, n, 32'd0});
				return;
			end
			if (c == 1) return;
			k = wk.size();
			if (k > 0 && wk[k-1].s + wk[k-1].l == p && wk[k-1].c == c &&
					{1'b0, wk[k-1].l} + n <= rrt_pkg::LEN_MAX)
				wk[k-1].l += n;
			else if (k < WORK_SIZE)
				wk.push_back('{p, n, c});
		endfunction

		function void sweep(logic [63:0] a, logic [63:0] b, bit inc);
			int i;
			logic [63:0] p, rend, segend, gend;
			i = 0;
			wk.delete();
			fr.delete();
			while (i < rec_used && rec_start[i] + rec_len[i] <= a) begin
				emit(rec_start[i], rec_start[i] + rec_len[i], rec_cnt[i]);
				i++;
			end
			if (i < rec_used && rec_start[i] < a && rec_start[i] + rec_len[i] > a)
				emit(rec_start[i], a, rec_cnt[i]);
			p = a;
			while (p < b) begin
				if (i < rec_used && rec_start[i] <= p && p < rec_start[i] + rec_len[i]) begin
					rend = rec_start[i] + rec_len[i];
					segend = (rend < b) ? rend : b;
					emit(p, segend, bump(rec_cnt[i], inc));
					p = segend;
					if (rend <= b) i++;
				end else begin
					gend = (i < rec_used && rec_start[i] < b) ? rec_start[i] : b;
					emit(p, gend, inc ? 32'd2 : 32'd0);
					p = gend;
				end
			end
			if (i < rec_used && rec_start[i] < b && rec_start[i] + rec_len[i] > b) begin
				emit(b, rec_start[i] + rec_len[i], rec_cnt[i]);
				i++;
			end
			while (i < rec_used) begin
				emit(rec_start[i], rec_start[i] + rec_len[i], rec_cnt[i]);
				i++;
			end
		endfunction

		function void note_request(logic [1:0] m, logic [63:0] s, logic [31:0] l);
			bit in_grp;
			logic [31:0] c;
			logic [64:0] top;
			int n;
			in_grp = (s >= grp_first) && ((s - grp_first) < grp_count);
			top = {1'b0, s} + l;
			if (m == rrt_pkg::MODE_LOOKUP) begin
				c = 32'd1;
				if (in_grp) begin
					for (int i = 0; i < rec_used; i++) begin
						if (s >= rec_start[i] && s < rec_start[i] + rec_len[i]) begin
							c = rec_cnt[i];
							break;
						end
						if (rec_start[i] > s) break;
					end
				end
				pending.push_back('{rrt_pkg::STAT_OK, c, 1'b0, 64'd0, 32'd0, 1'b1});
				return;
			end
			if (m == rrt_pkg::MODE_NONE || !in_grp || l == 0 || top[64]) begin
				pending.push_back('{rrt_pkg::STAT_INVALID, 32'd0, 1'b0, 64'd0, 32'd0, 1'b1});
				return;
			end
			sweep(s, top[63:0], m == rrt_pkg::MODE_INC);
			if (wk.size() > rrt_pkg::TABLE_RECORDS) begin
				pending.push_back('{rrt_pkg::STAT_FULL, 32'd0, 1'b0, 64'd0, 32'd0, 1'b1});
				return;
			end
			foreach (wk[i]) begin
				rec_start[i] = wk[i].s;
				rec_len[i] = wk[i].l;
				rec_cnt[i] = wk[i].c;
			end
			rec_used = wk.size();
			if (m == rrt_pkg::MODE_INC || fr.size() == 0) begin
				pending.push_back('{rrt_pkg::STAT_OK, 32'd0, 1'b0, 64'd0, 32'd0, 1'b1});
				return;
			end
			n = (fr.size() < rrt_pkg::TABLE_RECORDS + 1) ? fr.size() :
				rrt_pkg::TABLE_RECORDS + 1;
			for (int i = 0; i < n; i++)
				pending.push_back('{rrt_pkg::STAT_OK, 32'd0, 1'b1, fr[i].s, fr[i].l,
					i + 1 == n});
		endfunction

		task check_result(result_t got);
			result_t exp_r;
			if (pending.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			exp_r = pending.pop_front();
			if (got.st !== exp_r.st)
				report($sformatf("status %0d, want %0d", got.st, exp_r.st));
			if (got.rc !== exp_r.rc)
				report($sformatf("refcount %0d, want %0d", got.rc, exp_r.rc));
			if (got.fv !== exp_r.fv)
				report($sformatf("freed_valid %0b, want %0b", got.fv, exp_r.fv));
			if (got.fs !== exp_r.fs)
				report($sformatf("freed_start %h, want %h", got.fs, exp_r.fs));
			if (got.fl !== exp_r.fl)
				report($sformatf("freed_length %h, want %h", got.fl, exp_r.fl));
			if (got.lst !== exp_r.lst)
				report($sformatf("last %0b, want %0b", got.lst, exp_r.lst));
		endtask
	endclass

	refcount_scoreboard sb = new();

	range_refcount_table i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .start_block(start_block), .range_length(range_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .refcount(refcount), .freed_valid(freed_valid),
		.freed_start(freed_start), .freed_length(freed_length), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	task automatic send_request(input logic [1:0] m, input logic [63:0] s,
			input logic [31:0] l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		start_block = s;
		range_length = l;
		do @(posedge clk); while (in_stall);
		sb.note_request(m, s, l);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] v);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_group(input logic [63:0] f, input logic [63:0] c);
		drain();
		write_reg(rrt_pkg::CFG_FIRST, f);
		write_reg(rrt_pkg::CFG_COUNT, c);
	endtask

	task automatic random_phase(input int items, input logic [63:0] f,
			input logic [63:0] c, input bit wide);
		logic [1:0]  m;
		logic [63:0] s;
		logic [31:0] l;
		int r;
		for (int k = 0; k < items; k++) begin
			r = $urandom_range(0, 99);
			m = (r < 20) ? rrt_pkg::MODE_LOOKUP : (r < 60) ? rrt_pkg::MODE_INC :
				(r < 96) ? MODE_DEC : rrt_pkg::MODE_NONE;
			if (wide) begin
				s = {$urandom, $urandom};
				l = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 64);
			end else begin
				s = f + $urandom_range(0, c - 1);
				l = $urandom_range(1, 40);
				r = $urandom_range(0, 19);
				if (r == 0) l = 0;
				if (r == 1) s = f - 1;
				if (r == 2) s = f + c;
			end
			send_request(m, s, l);
			if (k == items / 2 && !wide) begin
				drain();
				calm = !calm;
			end
		end
	endtask

	initial begin
		result_t got;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			repeat (calm ? 0 : $urandom_range(0, 11)) begin
				out_stall = 1'b1;
				@(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			got = '{status, refcount, freed_valid, freed_start, freed_length, last};
			sb.check_result(got);
		end
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = rrt_pkg::MODE_LOOKUP;
		start_block = '0;
		range_length = '0;
		cfg_valid = 1'b0;
		cfg_index = rrt_pkg::CFG_FIRST;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(rrt_pkg::MODE_INC, 64'd0, 32'd4);
		set_group(64'd1000, 64'd300);
		send_request(rrt_pkg::MODE_LOOKUP, 64'd999, 32'd0);
		send_request(rrt_pkg::MODE_NONE, 64'd1000, 32'd5);
		send_request(rrt_pkg::MODE_INC, 64'd1000, 32'd0);
		send_request(rrt_pkg::MODE_INC, 64'd999, 32'd3);
		send_request(MODE_DEC, 64'd1300, 32'd3);
		send_request(rrt_pkg::MODE_INC, 64'd1000, 32'd10);
		send_request(rrt_pkg::MODE_INC, 64'd1005, 32'd10);
		send_request(rrt_pkg::MODE_LOOKUP, 64'd1007, 32'd0);
		send_request(MODE_DEC, 64'd1000, 32'd20);
		send_request(MODE_DEC, 64'd1000, 32'd20);
		send_request(rrt_pkg::MODE_INC, 64'd1290, 32'd50);
		for (int k = 0; k < 33; k++)
			send_request(rrt_pkg::MODE_INC, 64'd1100 + 2 * k, 32'd1);
		send_request(MODE_DEC, 64'd1100, 32'd66);
		set_group(BLK_MAX - 99, 64'd100);
		send_request(rrt_pkg::MODE_INC, BLK_MAX - 5, 32'd6);
		send_request(rrt_pkg::MODE_INC, BLK_MAX - 5, 32'd5);
		send_request(rrt_pkg::MODE_LOOKUP, BLK_MAX - 1, 32'd0);
		set_group(64'd0, BLK_MAX);
		send_request(rrt_pkg::MODE_INC, 64'd0, rrt_pkg::LEN_MAX);
		send_request(rrt_pkg::MODE_INC, 64'h0000_0000_FFFF_FFFF, 32'd10);
		send_request(MODE_DEC, 64'd0, rrt_pkg::LEN_MAX);
		send_request(MODE_DEC, 64'd0, rrt_pkg::LEN_MAX);
		set_group(64'd50, 64'd0);
		send_request(rrt_pkg::MODE_LOOKUP, 64'd50, 32'd0);

		set_group(64'd1000, 64'd300);
		random_phase(100, 64'd1000, 64'd300, 0);
		set_group(64'd0, BLK_MAX);
		random_phase(60, 64'd0, BLK_MAX, 1);
		set_group(BLK_MAX - 511, 64'd512);
		random_phase(60, BLK_MAX - 511, 64'd512, 0);
		set_group({$urandom, 32'd0}, 64'd4096);
		random_phase(60, sb.grp_first, 64'd4096, 0);

		drain();
		if (error_count == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rrt_pkg.sv
rtl/core/rrt_cell.sv
rtl/core/rrt_merge.sv
rtl/core/range_refcount_table.sv
bench/testbench.sv
